// ===== hw/rtl/crc16_frame_receiver_unit_defines.svh =====
// ----------------------------------------------------------------------------
// CRC-16 frame receiver assertion macros
// Shared concurrent assertion forms for the frame receiver RTL.
// ----------------------------------------------------------------------------
`ifndef CRC16_FRAME_RECEIVER_UNIT_DEFINES_SVH
`define CRC16_FRAME_RECEIVER_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define CRCFR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("crcfr assertion failed");

// next-cycle implication, disabled during reset
`define CRCFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("crcfr assertion failed");

`endif

// ===== hw/rtl/crcfr_pkg.sv =====
// ----------------------------------------------------------------------------
// CRC-16 frame receiver package
// Widths, frame layout offsets, CRC constants and register indexes.
// ----------------------------------------------------------------------------
package crcfr_pkg;

    localparam int BYTE_W        = 8;
    localparam int LEN_W         = 7;
    localparam int IDX_W         = 6;
    localparam int CRC_W         = 16;

    localparam int PAYLOAD_LIMIT = 64;
    localparam int HDR_BYTES     = 9;
    localparam int STORE_DEPTH   = HDR_BYTES + PAYLOAD_LIMIT;
    localparam int PTR_W         = $clog2(STORE_DEPTH + 1);

    localparam int OFF_SYNC0     = 0;
    localparam int OFF_SYNC1     = 1;
    localparam int OFF_ADDR      = 2;
    localparam int OFF_CMD       = 3;
    localparam int OFF_SEQ       = 4;
    localparam int OFF_LEN_LO    = 5;
    localparam int OFF_LEN_HI    = 6;
    localparam int OFF_PAYLOAD   = 7;
    localparam int OFF_CRC_HI    = 8;

    localparam logic [CRC_W-1:0]  CRC_INIT = 16'hFFFF;
    localparam logic [CRC_W-1:0]  CRC_POLY = 16'h1021;

    localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'hAA;
    localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'h55;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 2'd1;

    typedef struct packed {
        logic [BYTE_W-1:0] dest_addr;
        logic [BYTE_W-1:0] command;
        logic [BYTE_W-1:0] sequence_res;
        logic [LEN_W-1:0]  payload_len;
        logic [IDX_W-1:0]  byte_index;
        logic [BYTE_W-1:0] payload_byte;
        logic              has_byte;
        logic              last;
    } t_frame_result;

endpackage

// ===== hw/rtl/crcfr_rx_if.sv =====
// ----------------------------------------------------------------------------
// Received byte channel
// Valid/ready channel carrying one received byte per transfer.
// ----------------------------------------------------------------------------
interface crcfr_rx_if;
    logic                       valid;
    logic                       ready;
    logic [crcfr_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== hw/rtl/crcfr_res_if.sv =====
// ----------------------------------------------------------------------------
// Frame result channel
// Valid/ready channel carrying one result of an accepted frame per transfer.
// ----------------------------------------------------------------------------
interface crcfr_res_if;
    logic                         valid;
    logic                         ready;
    logic [crcfr_pkg::BYTE_W-1:0] dest_addr;
    logic [crcfr_pkg::BYTE_W-1:0] command;
    logic [crcfr_pkg::BYTE_W-1:0] sequence_res;
    logic [crcfr_pkg::LEN_W-1:0]  payload_len;
    logic [crcfr_pkg::IDX_W-1:0]  byte_index;
    logic [crcfr_pkg::BYTE_W-1:0] payload_byte;
    logic                         has_byte;
    logic                         last;

    modport source (
        output valid, output dest_addr, output command, output sequence_res,
        output payload_len, output byte_index, output payload_byte,
        output has_byte, output last, input ready
    );
    modport sink (
        input valid, input dest_addr, input command, input sequence_res,
        input payload_len, input byte_index, input payload_byte,
        input has_byte, input last, output ready
    );
endinterface

// ===== hw/rtl/crc16_frame_receiver_unit.sv =====
// ----------------------------------------------------------------------------
// CRC-16 frame receiver
// Sync hunt, length check, bit-serial CRC-16/CCITT-FALSE and payload output.
// ----------------------------------------------------------------------------
// Bytes are taken one per transfer, only while the sequencer is idle, into a
// 73-entry circular frame store with one write and one registered read port.
// After each byte the held bytes are rescanned: a byte failing the sync hunt
// or the length check is dropped, an incomplete frame waits in idle for more
// bytes, and a complete frame of L payload bytes runs the CRC over its 5 + L
// bytes from the address on (one bit per cycle, one store read per byte),
// then fetches the CRC and header and issues its results as fast as the result
// channel takes them. The last result waits in an output register while the
// next byte is already taken. A frame failing its CRC is dropped whole and
// scanning resumes after it. No clearing pass is needed after reset.
`include "crc16_frame_receiver_unit_defines.svh"

module crc16_frame_receiver_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [crcfr_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [crcfr_pkg::BYTE_W-1:0]      i_cfg_data,
    crcfr_rx_if.sink                          i_rx,
    crcfr_res_if.source                       o_res
);

    localparam int PW = crcfr_pkg::PTR_W;
    localparam int BW = crcfr_pkg::BYTE_W;
    localparam int LW = crcfr_pkg::LEN_W;
    localparam int KW = crcfr_pkg::IDX_W;
    localparam int CW = crcfr_pkg::CRC_W;

    typedef enum logic [13:0] {
        S_IDLE    = 14'b00000000000001,
        S_SCAN    = 14'b00000000000010,
        S_SYNC0   = 14'b00000000000100,
        S_SYNC1   = 14'b00000000001000,
        S_LEN0    = 14'b00000000010000,
        S_LEN1    = 14'b00000000100000,
        S_CRC_LD  = 14'b00000001000000,
        S_CRC_BIT = 14'b00000010000000,
        S_RX0     = 14'b00000100000000,
        S_RX1     = 14'b00001000000000,
        S_HDR0    = 14'b00010000000000,
        S_HDR1    = 14'b00100000000000,
        S_HDR2    = 14'b01000000000000,
        S_EMIT    = 14'b10000000000000
    } t_state;

    function automatic logic [PW-1:0] ptr_add(input logic [PW-1:0] a,
                                              input logic [PW-1:0] b);
        logic [PW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (PW+1)'(crcfr_pkg::STORE_DEPTH)) begin
            s = s - (PW+1)'(crcfr_pkg::STORE_DEPTH);
        end
        return s[PW-1:0];
    endfunction

    t_state                   r_state, n_state;
    logic [PW-1:0]            r_count, n_count;
    logic [PW-1:0]            r_base, n_base;
    logic [BW-1:0]            r_sync_first, r_sync_second;
    logic                     r_out_valid, n_out_valid;

    logic [BW-1:0]            r_tmp, n_tmp;
    logic [LW-1:0]            r_len, n_len;
    logic [PW-1:0]            r_off, n_off;
    logic [CW-1:0]            r_crc, n_crc;
    logic [BW-1:0]            r_shift, n_shift;
    logic [2:0]               r_bit, n_bit;
    logic [KW-1:0]            r_k, n_k;
    logic [BW-1:0]            r_hdr_addr, n_hdr_addr;
    logic [BW-1:0]            r_hdr_cmd, n_hdr_cmd;
    logic [BW-1:0]            r_hdr_seq, n_hdr_seq;
    crcfr_pkg::t_frame_result r_out, n_out;

    logic [BW-1:0]            mem [crcfr_pkg::STORE_DEPTH];
    logic [BW-1:0]            r_rd_data;
    logic [PW-1:0]            rd_off;
    logic [PW-1:0]            rd_addr;
    logic [PW-1:0]            wr_addr;
    logic                     wr_en;
    logic                     rx_xfer;
    logic                     res_free;
    logic                     crc_fb;
    logic                     res_last;
    logic [PW-1:0]            flen_cur;
    logic [PW-1:0]            flen_new;

    assign rx_xfer   = i_rx.valid && i_rx.ready;
    assign res_free  = !r_out_valid || o_res.ready;
    assign crc_fb    = r_crc[CW-1] ^ r_shift[BW-1];
    assign flen_cur  = PW'(crcfr_pkg::HDR_BYTES) + PW'(r_len);
    assign flen_new  = PW'(crcfr_pkg::HDR_BYTES) + PW'(r_tmp);
    assign res_last  = (r_len == '0) || ((LW'(r_k) + LW'(1)) == r_len);
    assign rd_addr   = ptr_add(r_base, rd_off);
    assign wr_addr   = ptr_add(r_base, r_count);
    assign wr_en     = rx_xfer && (r_count != PW'(crcfr_pkg::STORE_DEPTH));

    assign i_rx.ready         = (r_state == S_IDLE);
    assign o_res.valid        = r_out_valid;
    assign o_res.dest_addr    = r_out.dest_addr;
    assign o_res.command      = r_out.command;
    assign o_res.sequence_res = r_out.sequence_res;
    assign o_res.payload_len  = r_out.payload_len;
    assign o_res.byte_index   = r_out.byte_index;
    assign o_res.payload_byte = r_out.payload_byte;
    assign o_res.has_byte     = r_out.has_byte;
    assign o_res.last         = r_out.last;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_base      = r_base;
        n_out_valid = r_out_valid && !o_res.ready;
        n_tmp       = r_tmp;
        n_len       = r_len;
        n_off       = r_off;
        n_crc       = r_crc;
        n_shift     = r_shift;
        n_bit       = r_bit;
        n_k         = r_k;
        n_hdr_addr  = r_hdr_addr;
        n_hdr_cmd   = r_hdr_cmd;
        n_hdr_seq   = r_hdr_seq;
        n_out       = r_out;
        rd_off      = PW'(crcfr_pkg::OFF_SYNC0);

        unique case (r_state)
            S_IDLE: begin
                if (rx_xfer) begin
                    if (r_count == PW'(crcfr_pkg::STORE_DEPTH)) begin
                        n_count = '0;
                    end else begin
                        n_count = r_count + PW'(1);
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                rd_off = PW'(crcfr_pkg::OFF_SYNC0);
                if (r_count < PW'(2)) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_SYNC0;
                end
            end
            S_SYNC0: begin
                rd_off = PW'(crcfr_pkg::OFF_SYNC1);
                if (r_rd_data != r_sync_first) begin
                    n_base  = ptr_add(r_base, PW'(1));
                    n_count = r_count - PW'(1);
                    n_state = S_SCAN;
                end else begin
                    n_state = S_SYNC1;
                end
            end
            S_SYNC1: begin
                rd_off = PW'(crcfr_pkg::OFF_LEN_LO);
                if (r_rd_data != r_sync_second) begin
                    n_base  = ptr_add(r_base, PW'(1));
                    n_count = r_count - PW'(1);
                    n_state = S_SCAN;
                end else if (r_count < PW'(crcfr_pkg::HDR_BYTES)) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_LEN0;
                end
            end
            S_LEN0: begin
                rd_off  = PW'(crcfr_pkg::OFF_LEN_HI);
                n_tmp   = r_rd_data;
                n_state = S_LEN1;
            end
            S_LEN1: begin
                rd_off = PW'(crcfr_pkg::OFF_ADDR);
                if ((r_rd_data != '0) || (r_tmp > BW'(crcfr_pkg::PAYLOAD_LIMIT))) begin
                    n_base  = ptr_add(r_base, PW'(1));
                    n_count = r_count - PW'(1);
                    n_state = S_SCAN;
                end else if (r_count < flen_new) begin
                    n_state = S_IDLE;
                end else begin
                    n_len   = LW'(r_tmp);
                    n_off   = PW'(crcfr_pkg::OFF_ADDR);
                    n_crc   = crcfr_pkg::CRC_INIT;
                    n_state = S_CRC_LD;
                end
            end
            S_CRC_LD: begin
                n_shift = r_rd_data;
                n_bit   = '0;
                n_state = S_CRC_BIT;
            end
            S_CRC_BIT: begin
                n_crc   = {r_crc[CW-2:0], 1'b0} ^ (crc_fb ? crcfr_pkg::CRC_POLY : '0);
                n_shift = {r_shift[BW-2:0], 1'b0};
                n_bit   = r_bit + 3'd1;
                if (r_bit == 3'd7) begin
                    if (r_off == (PW'(crcfr_pkg::OFF_LEN_HI) + PW'(r_len))) begin
                        rd_off  = PW'(crcfr_pkg::OFF_PAYLOAD) + PW'(r_len);
                        n_state = S_RX0;
                    end else begin
                        rd_off  = r_off + PW'(1);
                        n_off   = r_off + PW'(1);
                        n_state = S_CRC_LD;
                    end
                end
            end
            S_RX0: begin
                rd_off  = PW'(crcfr_pkg::OFF_CRC_HI) + PW'(r_len);
                n_tmp   = r_rd_data;
                n_state = S_RX1;
            end
            S_RX1: begin
                rd_off = PW'(crcfr_pkg::OFF_ADDR);
                if ({r_rd_data, r_tmp} == r_crc) begin
                    n_state = S_HDR0;
                end else begin
                    n_base  = ptr_add(r_base, flen_cur);
                    n_count = r_count - flen_cur;
                    n_state = S_SCAN;
                end
            end
            S_HDR0: begin
                rd_off     = PW'(crcfr_pkg::OFF_CMD);
                n_hdr_addr = r_rd_data;
                n_state    = S_HDR1;
            end
            S_HDR1: begin
                rd_off    = PW'(crcfr_pkg::OFF_SEQ);
                n_hdr_cmd = r_rd_data;
                n_state   = S_HDR2;
            end
            S_HDR2: begin
                rd_off    = PW'(crcfr_pkg::OFF_PAYLOAD);
                n_hdr_seq = r_rd_data;
                n_k       = '0;
                n_state   = S_EMIT;
            end
            S_EMIT: begin
                rd_off = PW'(crcfr_pkg::OFF_PAYLOAD) + PW'(r_k);
                if (res_free) begin
                    n_out_valid        = 1'b1;
                    n_out.dest_addr    = r_hdr_addr;
                    n_out.command      = r_hdr_cmd;
                    n_out.sequence_res = r_hdr_seq;
                    n_out.payload_len  = r_len;
                    n_out.byte_index   = r_k;
                    n_out.payload_byte = (r_len == '0) ? '0 : r_rd_data;
                    n_out.has_byte     = (r_len != '0);
                    n_out.last         = res_last;
                    if (res_last) begin
                        n_base  = ptr_add(r_base, flen_cur);
                        n_count = r_count - flen_cur;
                        n_state = S_IDLE;
                    end else begin
                        rd_off = PW'(crcfr_pkg::OFF_PAYLOAD) + PW'(r_k) + PW'(1);
                        n_k    = r_k + KW'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_count       <= '0;
            r_base        <= '0;
            r_out_valid   <= 1'b0;
            r_sync_first  <= crcfr_pkg::SYNC_FIRST_RST;
            r_sync_second <= crcfr_pkg::SYNC_SECOND_RST;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_base      <= n_base;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    crcfr_pkg::CFG_SYNC_FIRST:  r_sync_first  <= i_cfg_data;
                    crcfr_pkg::CFG_SYNC_SECOND: r_sync_second <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_tmp      <= n_tmp;
        r_len      <= n_len;
        r_off      <= n_off;
        r_crc      <= n_crc;
        r_shift    <= n_shift;
        r_bit      <= n_bit;
        r_k        <= n_k;
        r_hdr_addr <= n_hdr_addr;
        r_hdr_cmd  <= n_hdr_cmd;
        r_hdr_seq  <= n_hdr_seq;
        r_out      <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= i_rx.rx_byte;
        end
        r_rd_data <= mem[rd_addr];
    end

    `CRCFR_ASSERT_NEXT(a_rx_starts_scan, i_clk, i_rst_n, rx_xfer,
        (r_state == S_SCAN) || (r_state == S_IDLE))
    `CRCFR_ASSERT_IMPL(a_base_in_range, i_clk, i_rst_n, 1'b1,
        (r_base < PW'(crcfr_pkg::STORE_DEPTH)) && (r_count <= PW'(crcfr_pkg::STORE_DEPTH)))
    `CRCFR_ASSERT_IMPL(a_emit_index, i_clk, i_rst_n, r_state == S_EMIT,
        (r_len == '0) || (LW'(r_k) < r_len))
    `CRCFR_ASSERT_IMPL(a_hdr_after_crc, i_clk, i_rst_n, r_state == S_HDR0,
        $past(r_state) == S_RX1)

endmodule
